/* hw/rtl/ofss_pkg.sv */
// shared constants and types of the outlier-filtered sample statistics block
package ofss_pkg;

	localparam int DEF_STORE_DEPTH = 512;
	localparam int DEF_SAMPLE_BITS = 24;

	localparam int IN_W    = 24;
	localparam int CFG_W   = 8;
	localparam int CNT_OUT_W = 10;
	localparam int MEAN_W  = 24;
	localparam int VAR_W   = 48;
	localparam int QW      = 64;
	localparam int QCW     = $clog2(QW);

	localparam logic [CFG_W-1:0] FACTOR_RESET = 8'd9;

	typedef enum logic [1:0] {
		DIV_MEAN  = 2'd0,
		DIV_VAR   = 2'd1,
		DIV_KMEAN = 2'd2,
		DIV_KVAR  = 2'd3
	} div_sel_t;

	typedef struct packed {
		logic     load_en;
		logic     pass_clr;
		logic     pass2;
		logic     rd_en;
		logic     div_start;
		div_sel_t div_sel;
		logic     lim_en;
		logic     res_en;
		logic     res_small;
	} cmd_t;

	typedef struct packed {
		logic small_batch;
		logic rd_last;
		logic pipe_busy;
		logic div_busy;
		logic div_done;
	} stat_t;

endpackage

/* hw/rtl/ofss_div.sv */
// restoring divider, one quotient bit per cycle
module ofss_div #(
	parameter int DVS_W = 10
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [ofss_pkg::QW-1:0]   dividend,
	input  logic [DVS_W-1:0]          divisor,
	output logic                      busy,
	output logic                      done,
	output logic [ofss_pkg::QW-1:0]   quotient
);

	logic [ofss_pkg::QW-1:0]  quo_q;
	logic [DVS_W-1:0]         rem_q;
	logic [DVS_W-1:0]         dvs_q;
	logic [ofss_pkg::QCW-1:0] cnt_q;
	logic                     busy_q;
	logic                     done_q;
	logic [DVS_W:0]           trial;
	logic                     ge;
	logic [DVS_W:0]           diff;

	assign trial = {rem_q, quo_q[ofss_pkg::QW-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ofss_pkg::QCW'(ofss_pkg::QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[ofss_pkg::QW-2:0], ge};
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* hw/rtl/ofss_dp.sv */
// datapath: sample store, pass pipeline, accumulators, divider and result registers
module ofss_dp #(
	parameter int STORE_DEPTH = ofss_pkg::DEF_STORE_DEPTH,
	parameter int SAMPLE_BITS = ofss_pkg::DEF_SAMPLE_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ofss_pkg::cmd_t                  cmd,
	output ofss_pkg::stat_t                 stat,
	input  logic                            cfg_we,
	input  logic [ofss_pkg::CFG_W-1:0]      cfg_data,
	input  logic [ofss_pkg::IN_W-1:0]       sample_value,
	output logic [ofss_pkg::CNT_OUT_W-1:0]  kept_count,
	output logic [ofss_pkg::CNT_OUT_W-1:0]  outlier_count,
	output logic [ofss_pkg::MEAN_W-1:0]     kept_mean,
	output logic [ofss_pkg::VAR_W-1:0]      kept_variance,
	output logic                            overflow_flag
);

	localparam int CW  = $clog2(STORE_DEPTH + 1);
	localparam int IW  = $clog2(STORE_DEPTH);
	localparam int SW  = SAMPLE_BITS + CW;
	localparam int VW  = 2 * SAMPLE_BITS + CW;
	localparam int AW  = (VW > ofss_pkg::QW + 1) ? VW : ofss_pkg::QW + 1;
	localparam int LW  = ofss_pkg::QW + ofss_pkg::CFG_W;
	localparam int QW  = ofss_pkg::QW;

	logic [SAMPLE_BITS-1:0] store_mem [STORE_DEPTH];

	logic [ofss_pkg::CFG_W-1:0] factor_q;
	logic [CW-1:0]          cnt_q;
	logic [SW-1:0]          sum_q;
	logic                   drop_q;
	logic [IW-1:0]          addr_q;
	logic                   pass2_q;
	logic [SAMPLE_BITS-1:0] rdata_s1;
	logic                   v_s1;
	logic [2*SAMPLE_BITS-1:0] sq_s2;
	logic [SAMPLE_BITS-1:0] x_s2;
	logic                   v_s2;
	logic [SAMPLE_BITS-1:0] mean_q;
	logic [QW-1:0]          var_q;
	logic [LW-1:0]          limit_q;
	logic [AW-1:0]          vsum_q;
	logic [CW-1:0]          kept_q;
	logic [SW-1:0]          ksum_q;
	logic [AW-1:0]          kvsum_q;
	logic [ofss_pkg::MEAN_W-1:0] kmean_q;
	logic [ofss_pkg::VAR_W-1:0]  kvar_q;
	ofss_pkg::div_sel_t     sel_q;

	logic [SAMPLE_BITS-1:0] x_in;
	logic                   room;
	logic [SAMPLE_BITS-1:0] delta;
	logic [QW-1:0]          vsum_sat;
	logic [QW-1:0]          kvsum_sat;
	logic [QW-1:0]          div_dvd;
	logic [CW-1:0]          div_dvs;
	logic                   div_busy;
	logic                   div_done;
	logic [QW-1:0]          div_quo;

	assign x_in  = SAMPLE_BITS'(sample_value);
	assign room  = cnt_q < CW'(STORE_DEPTH);
	assign delta = (rdata_s1 >= mean_q) ? rdata_s1 - mean_q : mean_q - rdata_s1;

	// sums saturate at the 64-bit ceiling before division
	assign vsum_sat  = (|vsum_q[AW-1:QW])  ? '1 : vsum_q[QW-1:0];
	assign kvsum_sat = (|kvsum_q[AW-1:QW]) ? '1 : kvsum_q[QW-1:0];

	always_comb begin
		unique case (cmd.div_sel)
			ofss_pkg::DIV_MEAN: begin
				div_dvd = QW'(sum_q);
				div_dvs = cnt_q;
			end
			ofss_pkg::DIV_VAR: begin
				div_dvd = vsum_sat;
				div_dvs = cnt_q - 1'b1;
			end
			ofss_pkg::DIV_KMEAN: begin
				div_dvd = QW'(ksum_q);
				div_dvs = kept_q;
			end
			ofss_pkg::DIV_KVAR: begin
				div_dvd = kvsum_sat;
				div_dvs = kept_q - 1'b1;
			end
			default: begin
				div_dvd = '0;
				div_dvs = '0;
			end
		endcase
	end

	ofss_div #(.DVS_W(CW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// store port: write on load, registered read during the passes
	always_ff @(posedge clk) begin
		if (cmd.load_en && room) begin
			store_mem[cnt_q[IW-1:0]] <= x_in;
		end
		if (cmd.rd_en) begin
			rdata_s1 <= store_mem[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= ofss_pkg::FACTOR_RESET;
			cnt_q    <= '0;
			sum_q    <= '0;
			drop_q   <= 1'b0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			addr_q   <= '0;
			pass2_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				factor_q <= cfg_data;
			end
			if (cmd.res_en) begin
				cnt_q  <= '0;
				sum_q  <= '0;
				drop_q <= 1'b0;
			end else if (cmd.load_en) begin
				if (room) begin
					cnt_q <= cnt_q + 1'b1;
					sum_q <= sum_q + SW'(x_in);
				end else begin
					drop_q <= 1'b1;
				end
			end
			if (cmd.pass_clr) begin
				addr_q  <= '0;
				pass2_q <= cmd.pass2;
			end else if (cmd.rd_en) begin
				addr_q <= addr_q + 1'b1;
			end
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		sq_s2 <= delta * delta;
		x_s2  <= rdata_s1;
		if (cmd.pass_clr) begin
			if (!cmd.pass2) begin
				vsum_q <= '0;
			end else begin
				kept_q  <= '0;
				ksum_q  <= '0;
				kvsum_q <= '0;
			end
		end else if (v_s2) begin
			if (!pass2_q) begin
				vsum_q <= vsum_q + AW'(sq_s2);
			end else if (LW'(sq_s2) <= limit_q) begin
				kept_q  <= kept_q + 1'b1;
				ksum_q  <= ksum_q + SW'(x_s2);
				kvsum_q <= kvsum_q + AW'(sq_s2);
			end
		end
		if (cmd.lim_en) begin
			limit_q <= LW'(var_q) * LW'(factor_q);
		end
		if (cmd.div_start) begin
			sel_q <= cmd.div_sel;
		end
		if (div_done) begin
			unique case (sel_q)
				ofss_pkg::DIV_MEAN:  mean_q <= SAMPLE_BITS'(div_quo);
				ofss_pkg::DIV_VAR:   var_q  <= div_quo;
				ofss_pkg::DIV_KMEAN: kmean_q <= (kept_q == '0) ? '0 :
					ofss_pkg::MEAN_W'(div_quo);
				ofss_pkg::DIV_KVAR:  kvar_q <= (kept_q < CW'(2)) ? '0 :
					ofss_pkg::VAR_W'(div_quo);
				default: ;
			endcase
		end
		if (cmd.res_en) begin
			overflow_flag <= drop_q;
			if (cmd.res_small) begin
				kept_count    <= ofss_pkg::CNT_OUT_W'(cnt_q);
				outlier_count <= '0;
				kept_mean     <= ofss_pkg::MEAN_W'(sum_q);
				kept_variance <= '0;
			end else begin
				kept_count    <= ofss_pkg::CNT_OUT_W'(kept_q);
				outlier_count <= ofss_pkg::CNT_OUT_W'(cnt_q - kept_q);
				kept_mean     <= kmean_q;
				kept_variance <= kvar_q;
			end
		end
	end

	assign stat.small_batch = cnt_q < CW'(2);
	assign stat.rd_last     = CW'(addr_q) == (cnt_q - 1'b1);
	assign stat.pipe_busy   = v_s1 | v_s2;
	assign stat.div_busy    = div_busy;
	assign stat.div_done    = div_done;

endmodule

/* hw/rtl/ofss_ctrl.sv */
// controller: batch sequencing over load, two passes and four divisions
module ofss_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            last_of_batch,
	output logic            out_valid,
	input  logic            out_ready,
	input  ofss_pkg::stat_t stat,
	output ofss_pkg::cmd_t  cmd
);

	typedef enum logic [11:0] {
		S_LOAD  = 12'b0000_0000_0001,
		S_CHK   = 12'b0000_0000_0010,
		S_MEAN  = 12'b0000_0000_0100,
		S_P1    = 12'b0000_0000_1000,
		S_P1W   = 12'b0000_0001_0000,
		S_VAR   = 12'b0000_0010_0000,
		S_LIM   = 12'b0000_0100_0000,
		S_P2    = 12'b0000_1000_0000,
		S_P2W   = 12'b0001_0000_0000,
		S_KMEAN = 12'b0010_0000_0000,
		S_KVAR  = 12'b0100_0000_0000,
		S_OUT   = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   small_q;
	logic   out_valid_q;

	assign in_ready  = state_q == S_LOAD;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.div_sel   = ofss_pkg::DIV_MEAN;
		cmd.load_en   = in_valid && in_ready;
		cmd.res_small = small_q;
		unique case (state_q)
			S_LOAD: begin
				if (in_valid && last_of_batch) begin
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				if (stat.small_batch) begin
					state_d = S_OUT;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = ofss_pkg::DIV_MEAN;
					state_d       = S_MEAN;
				end
			end
			S_MEAN: begin
				if (stat.div_done) begin
					cmd.pass_clr = 1'b1;
					state_d      = S_P1;
				end
			end
			S_P1: begin
				cmd.rd_en = 1'b1;
				if (stat.rd_last) begin
					state_d = S_P1W;
				end
			end
			S_P1W: begin
				if (!stat.pipe_busy) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = ofss_pkg::DIV_VAR;
					state_d       = S_VAR;
				end
			end
			S_VAR: begin
				if (stat.div_done) begin
					state_d = S_LIM;
				end
			end
			S_LIM: begin
				cmd.lim_en   = 1'b1;
				cmd.pass_clr = 1'b1;
				cmd.pass2    = 1'b1;
				state_d      = S_P2;
			end
			S_P2: begin
				cmd.rd_en = 1'b1;
				if (stat.rd_last) begin
					state_d = S_P2W;
				end
			end
			S_P2W: begin
				if (!stat.pipe_busy) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = ofss_pkg::DIV_KMEAN;
					state_d       = S_KMEAN;
				end
			end
			S_KMEAN: begin
				if (stat.div_done) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = ofss_pkg::DIV_KVAR;
					state_d       = S_KVAR;
				end
			end
			S_KVAR: begin
				if (stat.div_done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				// previous result must be taken before this one lands
				if (!out_valid_q) begin
					cmd.res_en = 1'b1;
					state_d    = S_LOAD;
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			small_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CHK) begin
				small_q <= stat.small_batch;
			end
			if (cmd.res_en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !stat.div_busy)
		else $error("divider started while busy");

	a_rd_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> (state_q == S_P1 || state_q == S_P2))
		else $error("store read outside a pass");

	a_res_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_en |-> !out_valid_q)
		else $error("result overwrote an untaken result");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_P1W && !stat.pipe_busy) |=> (state_q == S_VAR))
		else $error("first pass drained without starting variance division");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_en |-> !stat.pipe_busy && !stat.div_busy)
		else $error("sample loaded while batch computation active");

endmodule

/* hw/rtl/outlier_filtered_sample_stats.sv */
// in S_LOAD, samples go one per cycle into the store; a last-marked sample starts computation
// n <= 1 stored: no passes or divisions; result registered via S_CHK and S_OUT
// otherwise: two store passes at one read per cycle and four
// divisions on the shared one-bit-per-cycle divider; next batch loads once the result is queued
// reset clears sample count, sum, flags and result valid, sets the factor to 9; store not cleared
module outlier_filtered_sample_stats #(
	parameter int STORE_DEPTH = ofss_pkg::DEF_STORE_DEPTH,
	parameter int SAMPLE_BITS = ofss_pkg::DEF_SAMPLE_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ofss_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [ofss_pkg::IN_W-1:0]       sample_value,
	input  logic                            last_of_batch,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [ofss_pkg::CNT_OUT_W-1:0]  kept_count,
	output logic [ofss_pkg::CNT_OUT_W-1:0]  outlier_count,
	output logic [ofss_pkg::MEAN_W-1:0]     kept_mean,
	output logic [ofss_pkg::VAR_W-1:0]      kept_variance,
	output logic                            overflow_flag
);

	ofss_pkg::cmd_t  cmd;
	ofss_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	ofss_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.last_of_batch (last_of_batch),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.stat          (stat),
		.cmd           (cmd)
	);

	ofss_dp #(
		.STORE_DEPTH (STORE_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.sample_value  (sample_value),
		.kept_count    (kept_count),
		.outlier_count (outlier_count),
		.kept_mean     (kept_mean),
		.kept_variance (kept_variance),
		.overflow_flag (overflow_flag)
	);

endmodule

/* dv/tb_outlier_filtered_sample_stats.sv */
// testbench of the outlier-filtered sample statistics block: batches in, checked statistics out
module tb_outlier_filtered_sample_stats;

	localparam int DEPTH = ofss_pkg::DEF_STORE_DEPTH;

	typedef struct {
		logic [ofss_pkg::CNT_OUT_W-1:0] kept;
		logic [ofss_pkg::CNT_OUT_W-1:0] outl;
		logic [ofss_pkg::MEAN_W-1:0]    mean;
		logic [ofss_pkg::VAR_W-1:0]     vari;
		logic                           ovf;
	} stats_t;

	class batch_stats_board;
		logic [ofss_pkg::IN_W-1:0] held[DEPTH];
		int unsigned     held_n;
		logic [63:0]     sum;
		bit              dropped;
		logic [ofss_pkg::CFG_W-1:0] factor;
		stats_t          pending[$];
		int              errors;

		function new();
			held_n = 0;
			sum = 0;
			dropped = 0;
			factor = ofss_pkg::FACTOR_RESET;
			errors = 0;
		endfunction

		function logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
			logic [64:0] t;
			t = {1'b0, a} + {1'b0, b};
			return t[64] ? '1 : t[63:0];
		endfunction

		function logic [63:0] dist_sq(logic [63:0] x, logic [63:0] m);
			logic [63:0] d;
			logic [127:0] p;
			d = (x >= m) ? x - m : m - x;
			p = d * d;
			return (p[127:64] != 0) ? '1 : p[63:0];
		endfunction

		function void note_sample(logic [ofss_pkg::IN_W-1:0] v, bit last);
			stats_t r;
			logic [63:0] mean, vsum, vr, lim, ksum, kvsum, s;
			logic [127:0] prod;
			int unsigned kept;
			bit cap;
			if (held_n < DEPTH) begin
				held[held_n] = v;
				held_n++;
				sum += v;
			end else
				dropped = 1;
			if (!last)
				return;
			kept = 0;
			ksum = 0;
			kvsum = 0;
			vsum = 0;
			r.mean = 0;
			r.vari = 0;
			if (held_n <= 1) begin
				kept = held_n;
				if (held_n == 1)
					r.mean = held[0];
			end else begin
				mean = sum / held_n;
				for (int i = 0; i < held_n; i++)
					vsum = sat_sum(vsum, dist_sq(held[i], mean));
				vr = vsum / (held_n - 1);
				prod = vr * factor;
				cap = (factor != 0) && (prod[127:64] != 0);
				lim = prod[63:0];
				for (int i = 0; i < held_n; i++) begin
					s = dist_sq(held[i], mean);
					if (cap || s <= lim) begin
						kept++;
						ksum += held[i];
						kvsum = sat_sum(kvsum, s);
					end
				end
				if (kept != 0)
					r.mean = ofss_pkg::MEAN_W'(ksum / kept);
				if (kept >= 2)
					r.vari = ofss_pkg::VAR_W'(kvsum / (kept - 1));
			end
			r.kept = ofss_pkg::CNT_OUT_W'(kept);
			r.outl = ofss_pkg::CNT_OUT_W'(held_n - kept);
			r.ovf = dropped;
			pending.push_back(r);
			held_n = 0;
			sum = 0;
			dropped = 0;
		endfunction

		function void check_result(stats_t a);
			stats_t e;
			if (pending.size() == 0) begin
				$error("unexpected result transfer");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.kept !== e.kept) begin
				$error("kept_count exp %0d got %0d", e.kept, a.kept);
				errors++;
			end
			if (a.outl !== e.outl) begin
				$error("outlier_count exp %0d got %0d", e.outl, a.outl);
				errors++;
			end
			if (a.mean !== e.mean) begin
				$error("kept_mean exp %0d got %0d", e.mean, a.mean);
				errors++;
			end
			if (a.vari !== e.vari) begin
				$error("kept_variance exp %0d got %0d", e.vari, a.vari);
				errors++;
			end
			if (a.ovf !== e.ovf) begin
				$error("overflow_flag exp %0d got %0d", e.ovf, a.ovf);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [ofss_pkg::CFG_W-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_ready;
	logic [ofss_pkg::IN_W-1:0] sample_value = '0;
	logic last_of_batch = 0;
	logic out_valid;
	logic out_ready = 0;
	logic [ofss_pkg::CNT_OUT_W-1:0] kept_count, outlier_count;
	logic [ofss_pkg::MEAN_W-1:0] kept_mean;
	logic [ofss_pkg::VAR_W-1:0] kept_variance;
	logic overflow_flag;

	batch_stats_board board = new();
	bit quiet;
	bit drain_stall;

	always #10 clk = ~clk;

	outlier_filtered_sample_stats DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.sample_value(sample_value), .last_of_batch(last_of_batch),
		.out_valid(out_valid), .out_ready(out_ready),
		.kept_count(kept_count), .outlier_count(outlier_count),
		.kept_mean(kept_mean), .kept_variance(kept_variance),
		.overflow_flag(overflow_flag)
	);

	// result side: sample at the edge, then pick next ready
	int stall_left = 0;
	always @(posedge clk) begin
		stats_t a;
		if (arst_n && out_valid && out_ready) begin
			a.kept = kept_count;
			a.outl = outlier_count;
			a.mean = kept_mean;
			a.vari = kept_variance;
			a.ovf = overflow_flag;
			board.check_result(a);
		end
		if (quiet || !drain_stall)
			out_ready <= 1;
		else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 14) - 1;
			out_ready <= 0;
		end else
			out_ready <= 1;
	end

	// valid stays up between back-to-back transfers; it drops only for a random gap or while waiting for idle
	task automatic send_sample(logic [ofss_pkg::IN_W-1:0] v, bit last);
		if (!quiet && $urandom_range(0, 6) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1;
		sample_value <= v;
		last_of_batch <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.note_sample(v, last);
	endtask

	task automatic wait_idle();
		int guard;
		guard = 0;
		in_valid <= 0;
		while (board.pending.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
	endtask

	task automatic write_factor(logic [ofss_pkg::CFG_W-1:0] f);
		wait_idle();
		cfg_valid <= 1;
		cfg_data <= f;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		board.factor = f;
		cfg_valid <= 0;
	endtask

	function automatic logic [ofss_pkg::IN_W-1:0] rand_sample(int shape);
		case (shape)
			0: return ofss_pkg::IN_W'($urandom);
			1: return ofss_pkg::IN_W'(24'd1000 + $urandom_range(0, 40));
			2: return ($urandom_range(0, 15) == 0)
				? ofss_pkg::IN_W'(24'hFFFFF0 + $urandom_range(0, 15))
				: ofss_pkg::IN_W'($urandom_range(0, 255));
			default: return ofss_pkg::IN_W'($urandom_range(0, 7));
		endcase
	endfunction

	task automatic send_batch(int n, int shape);
		for (int i = 0; i < n; i++)
			send_sample(rand_sample(shape), i == n - 1);
	endtask

	initial begin
		int sent;
		int n;
		logic [ofss_pkg::CFG_W-1:0] fset[5] = '{8'd1, 8'd255, 8'd4, 8'd9, 8'd16};
		quiet = 0;
		drain_stall = 1;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: single samples, extremes, equal values, one clear outlier
		send_sample(24'd0, 1);
		send_sample(24'hFFFFFF, 1);
		send_sample(24'h000000, 0);
		send_sample(24'hFFFFFF, 1);
		send_sample(24'd5, 0);
		send_sample(24'd5, 0);
		send_sample(24'd5, 1);
		for (int i = 0; i < 10; i++)
			send_sample(24'd100, 0);
		send_sample(24'hFFFFFF, 1);
		send_sample(24'h555555, 0);
		send_sample(24'hAAAAAA, 1);
		write_factor(8'd1);
		send_sample(24'd10, 0);
		send_sample(24'd20, 0);
		send_sample(24'd30, 1);
		// store full: drop extras, last mark on a dropped sample
		write_factor(8'd9);
		for (int i = 0; i < DEPTH + 3; i++)
			send_sample(ofss_pkg::IN_W'($urandom_range(0, 3)), i == DEPTH + 2);

		sent = 0;
		for (int p = 0; p < 5; p++) begin
			write_factor(fset[p]);
			while (sent < (p + 1) * 130) begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 20);
				send_batch(n, $urandom_range(0, 3));
				sent += n;
			end
		end
		write_factor(ofss_pkg::CFG_W'($urandom_range(1, 255)));
		quiet = 1;
		for (int i = 0; i < 50; i++)
			send_sample(rand_sample(i % 4), (i % 10) == 9);
		wait_idle();
		if (board.errors == 0 && board.pending.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#40000000;
		$display("RESULT: ERROR");
		$finish;
	end
endmodule

/* sim.f */
hw/rtl/ofss_pkg.sv
hw/rtl/ofss_div.sv
hw/rtl/ofss_dp.sv
hw/rtl/ofss_ctrl.sv
hw/rtl/outlier_filtered_sample_stats.sv
dv/tb_outlier_filtered_sample_stats.sv
